// ===== rtl/core/json_string_field_extractor_macros.svh =====
// ----------------------------------------------------------------------------
// JSON string field extractor assertion macros
// Concurrent assertion helpers; they expand to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_FIELD_EXTRACTOR_MACROS_SVH
`define JSON_STRING_FIELD_EXTRACTOR_MACROS_SVH

`ifndef SYNTH

// Check that cons holds in the same cycle as ante
`define JSFE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante
`define JSFE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define JSFE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define JSFE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/core/jsfe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsfe_pkg
// Shared types and constants of the JSON string field extractor.
// ----------------------------------------------------------------------------
package jsfe_pkg;

    // Configuration port geometry
    localparam int KEY_LEN_W     = 6;
    localparam int LIMIT_W       = 16;
    localparam int KEY_WORDS     = 6;
    localparam int KEY_CFG_BYTES = 8 * KEY_WORDS;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 64;

    // Register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_KEY_LENGTH = 3'd0,
        CFG_KEY_WORD_0 = 3'd1,
        CFG_KEY_WORD_1 = 3'd2,
        CFG_KEY_WORD_2 = 3'd3,
        CFG_KEY_WORD_3 = 3'd4,
        CFG_KEY_WORD_4 = 3'd5,
        CFG_KEY_WORD_5 = 3'd6,
        CFG_OUT_LIMIT  = 3'd7
    } cfg_index_t;

    localparam logic [LIMIT_W-1:0] OUT_LIMIT_RESET = 16'd256;

    // Character codes
    localparam logic [7:0] CHAR_QUOTE     = 8'h22;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_COLON     = 8'h3A;
    localparam logic [7:0] CHAR_N         = 8'h6E;
    localparam logic [7:0] CHAR_R         = 8'h72;
    localparam logic [7:0] CHAR_T         = 8'h74;
    localparam logic [7:0] CHAR_LF        = 8'h0A;
    localparam logic [7:0] CHAR_CR        = 8'h0D;
    localparam logic [7:0] CHAR_TAB       = 8'h09;

    // Input request
    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } in_item_t;

    // Output request
    typedef struct packed {
        logic [7:0] value_byte;
        logic       byte_valid;
        logic       finished;
        logic       found;
    } out_item_t;

    // Window control from the phase machine
    typedef struct packed {
        logic shift;
        logic clear;
    } win_ctrl_t;

endpackage

// ===== rtl/core/jsfe_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsfe_window
// Sliding window of recent text bytes and the quoted-key match against it.
// ----------------------------------------------------------------------------
module jsfe_window #(
    parameter int MAX_KEY_BYTES = 48
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  jsfe_pkg::win_ctrl_t                ctrl,
    input  logic [7:0]                         text_byte,
    input  logic [jsfe_pkg::KEY_LEN_W-1:0]     key_length,
    input  logic [8*MAX_KEY_BYTES-1:0]         key_bytes,
    output logic                               match
);

    localparam int DEPTH   = MAX_KEY_BYTES + 2;
    localparam int FILL_W  = $clog2(DEPTH + 1);
    localparam int SHIFT_W = $clog2(DEPTH);
    localparam int CMP_W   = jsfe_pkg::KEY_LEN_W + 1;

    logic [7:0]          recent_reg [DEPTH];
    logic [FILL_W-1:0]   fill_reg;
    logic [FILL_W-1:0]   fill_next;

    logic [7:0]          win_shift [DEPTH];
    logic [8*DEPTH-1:0]  rev_key;
    logic [8*DEPTH-1:0]  aligned;
    logic [SHIFT_W-1:0]  shift_amt;
    logic [DEPTH-1:0]    byte_ok;
    logic                len_ok;
    logic                fill_ok;

    // Window as it stands after the incoming byte is shifted in (newest at 0)
    always_comb
    begin
        win_shift[0] = text_byte;
        for (int k = 1; k < DEPTH; k++)
        begin
            win_shift[k] = recent_reg[k-1];
        end
    end

    // Saturating fill count
    assign fill_next = (fill_reg == FILL_W'(DEPTH)) ? fill_reg : fill_reg + FILL_W'(1);

    // Reverse the key so that key byte m sits at byte MAX_KEY_BYTES - m
    always_comb
    begin
        rev_key = '0;
        for (int m = 0; m < MAX_KEY_BYTES; m++)
        begin
            rev_key[8*(MAX_KEY_BYTES-m) +: 8] = key_bytes[8*m +: 8];
        end
    end

    // Align so that byte k of the window meets key byte key_length - k
    assign shift_amt = SHIFT_W'(MAX_KEY_BYTES) - SHIFT_W'(key_length);
    assign aligned   = rev_key >> {shift_amt, 3'b000};

    // Compare every window position against quote, key byte or nothing
    always_comb
    begin
        for (int k = 0; k < DEPTH; k++)
        begin
            if (k == 0 || k == int'(key_length) + 1)
            begin
                byte_ok[k] = (win_shift[k] == jsfe_pkg::CHAR_QUOTE);
            end
            else if (k <= int'(key_length))
            begin
                byte_ok[k] = (win_shift[k] == aligned[8*k +: 8]);
            end
            else
            begin
                byte_ok[k] = 1'b1;
            end
        end
    end

    assign len_ok  = (key_length <= jsfe_pkg::KEY_LEN_W'(MAX_KEY_BYTES));
    assign fill_ok = (CMP_W'(fill_next) >= (CMP_W'(key_length) + CMP_W'(2)));
    assign match   = len_ok && fill_ok && (&byte_ok);

    // Fill count: clear on rearm, advance on shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            fill_reg <= '0;
        end
        else if (ctrl.shift)
        begin
            fill_reg <= fill_next;
        end
    end

    // Shift line of recent bytes
    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            for (int k = 0; k < DEPTH; k++)
            begin
                recent_reg[k] <= win_shift[k];
            end
        end
    end

endmodule

// ===== rtl/core/jsfe_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsfe_ctrl
// Phase machine: key search, separator skip, value copy with unescaping.
// ----------------------------------------------------------------------------
module jsfe_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             step,
    input  jsfe_pkg::in_item_t               item,
    input  logic [jsfe_pkg::LIMIT_W-1:0]     out_limit,
    input  logic                             cfg_bad,
    input  logic                             match,
    output jsfe_pkg::win_ctrl_t              win,
    output logic                             res_valid,
    output jsfe_pkg::out_item_t              res
);

    typedef enum logic [4:0] {
        PH_SEARCH = 5'b00001,
        PH_SKIP   = 5'b00010,
        PH_VALUE  = 5'b00100,
        PH_ESCAPE = 5'b01000,
        PH_DONE   = 5'b10000
    } phase_t;

    localparam int CNT_W = jsfe_pkg::LIMIT_W + 1;

    phase_t                          phase_reg;
    phase_t                          phase_next;
    logic [jsfe_pkg::LIMIT_W-1:0]    written_reg;
    logic [jsfe_pkg::LIMIT_W-1:0]    written_next;

    logic                            room;
    logic                            room_after;
    logic [7:0]                      esc_byte;

    // Space for one more byte now, and after one more is written
    assign room       = (CNT_W'(written_reg) + CNT_W'(1)) < CNT_W'(out_limit);
    assign room_after = (CNT_W'(written_reg) + CNT_W'(2)) < CNT_W'(out_limit);

    // Map the escaped character
    always_comb
    begin
        case (item.text_byte)
            jsfe_pkg::CHAR_N: esc_byte = jsfe_pkg::CHAR_LF;
            jsfe_pkg::CHAR_R: esc_byte = jsfe_pkg::CHAR_CR;
            jsfe_pkg::CHAR_T: esc_byte = jsfe_pkg::CHAR_TAB;
            default:          esc_byte = item.text_byte;
        endcase
    end

    // Next phase, counter and result for the request in hand
    always_comb
    begin
        phase_next   = phase_reg;
        written_next = written_reg;
        res          = '0;
        res_valid    = 1'b0;
        win          = '0;

        if (step)
        begin
            if (item.end_of_text)
            begin
                // Finish whatever is open, then rearm
                win.clear    = 1'b1;
                phase_next   = PH_SEARCH;
                written_next = '0;
                case (phase_reg)
                    PH_SEARCH, PH_SKIP:
                    begin
                        res_valid    = 1'b1;
                        res.finished = 1'b1;
                    end
                    PH_VALUE:
                    begin
                        res_valid    = 1'b1;
                        res.finished = 1'b1;
                        res.found    = 1'b1;
                    end
                    PH_ESCAPE:
                    begin
                        res_valid    = 1'b1;
                        res.finished = 1'b1;
                        res.found    = 1'b1;
                        if (room)
                        begin
                            res.byte_valid = 1'b1;
                            res.value_byte = jsfe_pkg::CHAR_BACKSLASH;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            else
            begin
                case (phase_reg)
                    PH_SEARCH:
                    begin
                        if (cfg_bad)
                        begin
                            res_valid    = 1'b1;
                            res.finished = 1'b1;
                        end
                        else
                        begin
                            win.shift = 1'b1;
                            if (match)
                            begin
                                phase_next = PH_SKIP;
                            end
                        end
                    end
                    PH_SKIP:
                    begin
                        if (item.text_byte == jsfe_pkg::CHAR_QUOTE)
                        begin
                            phase_next = PH_VALUE;
                            if (!room)
                            begin
                                res_valid    = 1'b1;
                                res.finished = 1'b1;
                                res.found    = 1'b1;
                            end
                        end
                        else if (item.text_byte != jsfe_pkg::CHAR_SPACE &&
                                 item.text_byte != jsfe_pkg::CHAR_COLON)
                        begin
                            res_valid    = 1'b1;
                            res.finished = 1'b1;
                        end
                    end
                    PH_VALUE:
                    begin
                        if (!room || item.text_byte == jsfe_pkg::CHAR_QUOTE)
                        begin
                            res_valid    = 1'b1;
                            res.finished = 1'b1;
                            res.found    = 1'b1;
                        end
                        else if (item.text_byte == jsfe_pkg::CHAR_BACKSLASH)
                        begin
                            phase_next = PH_ESCAPE;
                        end
                        else
                        begin
                            res_valid      = 1'b1;
                            res.byte_valid = 1'b1;
                            res.value_byte = item.text_byte;
                            written_next   = written_reg + jsfe_pkg::LIMIT_W'(1);
                            res.finished   = !room_after;
                            res.found      = !room_after;
                        end
                    end
                    PH_ESCAPE:
                    begin
                        phase_next = PH_VALUE;
                        if (!room)
                        begin
                            res_valid    = 1'b1;
                            res.finished = 1'b1;
                            res.found    = 1'b1;
                        end
                        else
                        begin
                            res_valid      = 1'b1;
                            res.byte_valid = 1'b1;
                            res.value_byte = esc_byte;
                            written_next   = written_reg + jsfe_pkg::LIMIT_W'(1);
                            res.finished   = !room_after;
                            res.found      = !room_after;
                        end
                    end
                    default:
                    begin
                    end
                endcase

                // Hold in done once extraction ends
                if (res.finished)
                begin
                    phase_next = PH_DONE;
                end
            end
        end
    end

    // Phase and written-byte count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_SEARCH;
            written_reg <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            written_reg <= written_next;
        end
    end

endmodule

// ===== rtl/core/json_string_field_extractor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_field_extractor
// Extracts the string value of a configured key from a streamed JSON text.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one text byte per
//   request, or an end-of-text marker that closes the document and rearms.
//   Output channel (out_valid / out_stall / out_data) carries zero or one
//   result per input request: an unescaped value byte, a finish flag with
//   found, or both together.
//   A request taken is held in the input register, and its result is then
//   registered in the output register. Throughput: one request per cycle
//   unless the output stalls; the limit is the window compare and phase
//   update. Configuration (cfg_write / cfg_index / cfg_data) must be written
//   while the block holds no request in flight; it does not enforce this.
//   Reset clears the phase, the window fill count, the written-byte count
//   and both channel valid bits; the configuration returns to key_length 0,
//   zero key words and out_limit 256.
//   When the receiver stalls, the result waits in the output register, one
//   more request is held in the input register, and then in_stall rises.
// ----------------------------------------------------------------------------
`include "json_string_field_extractor_macros.svh"

module json_string_field_extractor #(
    parameter int MAX_KEY_BYTES = 48
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Input channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  jsfe_pkg::in_item_t                   in_data,
    // Output channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output jsfe_pkg::out_item_t                  out_data,
    // Configuration write port
    input  logic                                 cfg_write,
    input  logic [jsfe_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [jsfe_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int KEY_USED = (MAX_KEY_BYTES < jsfe_pkg::KEY_CFG_BYTES) ?
                              MAX_KEY_BYTES : jsfe_pkg::KEY_CFG_BYTES;

    // Configuration registers
    logic [jsfe_pkg::KEY_LEN_W-1:0]   key_length_reg;
    logic [jsfe_pkg::CFG_DATA_W-1:0]  key_word_reg [jsfe_pkg::KEY_WORDS];
    logic [jsfe_pkg::LIMIT_W-1:0]     out_limit_reg;

    // Channel registers
    logic                             in_valid_reg;
    jsfe_pkg::in_item_t               in_data_reg;
    logic                             out_valid_reg;
    jsfe_pkg::out_item_t              out_data_reg;

    logic                             out_ready;
    logic                             step;
    logic                             cfg_bad;
    logic [8*MAX_KEY_BYTES-1:0]       key_bytes;
    logic                             match;
    logic                             res_valid;
    jsfe_pkg::out_item_t              res;
    jsfe_pkg::win_ctrl_t              win;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_length_reg <= '0;
            out_limit_reg  <= jsfe_pkg::OUT_LIMIT_RESET;
            for (int w = 0; w < jsfe_pkg::KEY_WORDS; w++)
            begin
                key_word_reg[w] <= '0;
            end
        end
        else if (cfg_write)
        begin
            case (jsfe_pkg::cfg_index_t'(cfg_index))
                jsfe_pkg::CFG_KEY_LENGTH: key_length_reg  <= cfg_data[jsfe_pkg::KEY_LEN_W-1:0];
                jsfe_pkg::CFG_KEY_WORD_0: key_word_reg[0] <= cfg_data;
                jsfe_pkg::CFG_KEY_WORD_1: key_word_reg[1] <= cfg_data;
                jsfe_pkg::CFG_KEY_WORD_2: key_word_reg[2] <= cfg_data;
                jsfe_pkg::CFG_KEY_WORD_3: key_word_reg[3] <= cfg_data;
                jsfe_pkg::CFG_KEY_WORD_4: key_word_reg[4] <= cfg_data;
                jsfe_pkg::CFG_KEY_WORD_5: key_word_reg[5] <= cfg_data;
                jsfe_pkg::CFG_OUT_LIMIT:  out_limit_reg   <= cfg_data[jsfe_pkg::LIMIT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Gather key bytes; bytes past the configured words read as zero
    always_comb
    begin
        key_bytes = '0;
        for (int m = 0; m < KEY_USED; m++)
        begin
            key_bytes[8*m +: 8] = key_word_reg[m/8][8*(m%8) +: 8];
        end
    end

    assign cfg_bad = (out_limit_reg == '0) ||
                     (key_length_reg > jsfe_pkg::KEY_LEN_W'(MAX_KEY_BYTES));

    // Advance the held request whenever the output register can take a result
    assign out_ready = !out_valid_reg || !out_stall;
    assign step      = in_valid_reg && out_ready;
    assign in_stall  = in_valid_reg && !out_ready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_data_reg <= in_data;
        end
    end

    jsfe_window #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (win),
        .text_byte  (in_data_reg.text_byte),
        .key_length (key_length_reg),
        .key_bytes  (key_bytes),
        .match      (match)
    );

    jsfe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .item      (in_data_reg),
        .out_limit (out_limit_reg),
        .cfg_bad   (cfg_bad),
        .match     (match),
        .win       (win),
        .res_valid (res_valid),
        .res       (res)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= step && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && step && res_valid)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A result that does not finish must carry a byte
    `JSFE_ASSERT_SAME(a_open_result_has_byte, clk, rst_n, out_valid && !out_data.finished, out_data.byte_valid, "unfinished result without a value byte")

    // found only comes with finished
    `JSFE_ASSERT_SAME(a_found_needs_finish, clk, rst_n, out_valid && out_data.found, out_data.finished, "found set without finished")

    // The input side stalls only behind a blocked result
    `JSFE_ASSERT_SAME(a_stall_only_when_blocked, clk, rst_n, in_stall, out_valid && out_stall, "input stalled while the output is free")

    // A blocked result is still presented in the next cycle
    `JSFE_ASSERT_NEXT(a_stall_holds_output, clk, rst_n, out_valid && out_stall, out_valid, "blocked result dropped")

endmodule

// ===== sim/json_string_field_extractor_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_field_extractor_test
// Streams directed and random JSON documents through the extractor under
// several key and buffer settings and idle patterns. A scoreboard predicts
// every result and checks each output request against it in order.
// ----------------------------------------------------------------------------

// Predicts extractor results and checks output requests against them
class field_value_board;

    typedef enum logic [2:0] {
        SCAN_KEY,
        SKIP_SEPARATORS,
        IN_VALUE,
        IN_ESCAPE,
        DOC_DONE
    } scan_phase_t;

    localparam int MAX_KEY      = 48;
    localparam int WINDOW_DEPTH = MAX_KEY + 2;

    logic [jsfe_pkg::KEY_LEN_W-1:0]  key_len;
    logic [63:0]                     key_word [jsfe_pkg::KEY_WORDS];
    logic [jsfe_pkg::LIMIT_W-1:0]    limit;
    scan_phase_t                     phase;
    logic [7:0]                      window [WINDOW_DEPTH];
    int unsigned                     fill;
    int unsigned                     written;
    jsfe_pkg::out_item_t             awaited [$];
    int unsigned                     errors;
    int unsigned                     result_count;

    function new();
        key_len = '0;
        foreach (key_word[i])
            key_word[i] = '0;
        limit        = jsfe_pkg::OUT_LIMIT_RESET;
        errors       = 0;
        result_count = 0;
        rearm();
    endfunction

    function void rearm();
        phase = SCAN_KEY;
        foreach (window[i])
            window[i] = 8'h00;
        fill    = 0;
        written = 0;
    endfunction

    function void write_config(jsfe_pkg::cfg_index_t idx, logic [63:0] data);
        case (idx)
            jsfe_pkg::CFG_KEY_LENGTH: key_len = data[jsfe_pkg::KEY_LEN_W-1:0];
            jsfe_pkg::CFG_OUT_LIMIT:  limit = data[jsfe_pkg::LIMIT_W-1:0];
            default:                  key_word[idx - jsfe_pkg::CFG_KEY_WORD_0] = data;
        endcase
    endfunction

    function int unsigned pending_count();
        return awaited.size();
    endfunction

    function bit room_left();
        return (written + 1) < limit;
    endfunction

    // Compare the newest key_len+2 bytes with the quoted key
    function bit window_hit();
        int unsigned n;
        int unsigned i;
        logic [7:0]  want;
        n = key_len + 2;
        if (n > WINDOW_DEPTH || fill < n)
            return 1'b0;
        for (i = 0; i < n; i++)
        begin
            if (i == 0 || i == n - 1)
                want = jsfe_pkg::CHAR_QUOTE;
            else
                want = key_word[(i - 1) >> 3][((i - 1) & 7) * 8 +: 8];
            if (window[n - 1 - i] != want)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function void push_result(logic [7:0] b, bit valid, bit fin, bit fnd);
        jsfe_pkg::out_item_t r;
        r.value_byte = valid ? b : 8'h00;
        r.byte_valid = valid;
        r.finished   = fin;
        r.found      = fin ? fnd : 1'b0;
        if (fin)
            phase = DOC_DONE;
        awaited.push_back(r);
    endfunction

    // Emit one value byte; finish when the buffer is then full
    function void put_value(logic [7:0] b);
        written++;
        push_result(b, 1'b1, !room_left(), 1'b1);
    endfunction

    // Advance the prediction by one accepted input request
    function void predict_request(jsfe_pkg::in_item_t req);
        logic [7:0] b;
        int         i;
        b = req.text_byte;
        if (req.end_of_text)
        begin
            case (phase)
                SCAN_KEY, SKIP_SEPARATORS: push_result(8'h00, 1'b0, 1'b1, 1'b0);
                IN_VALUE:                  push_result(8'h00, 1'b0, 1'b1, 1'b1);
                IN_ESCAPE:
                begin
                    if (room_left())
                        push_result(jsfe_pkg::CHAR_BACKSLASH, 1'b1, 1'b1, 1'b1);
                    else
                        push_result(8'h00, 1'b0, 1'b1, 1'b1);
                end
                default: ;
            endcase
            rearm();
            return;
        end
        case (phase)
            SCAN_KEY:
            begin
                if (limit == 0 || key_len > MAX_KEY)
                    push_result(8'h00, 1'b0, 1'b1, 1'b0);
                else
                begin
                    for (i = WINDOW_DEPTH - 1; i > 0; i--)
                        window[i] = window[i - 1];
                    window[0] = b;
                    if (fill < WINDOW_DEPTH)
                        fill++;
                    if (window_hit())
                        phase = SKIP_SEPARATORS;
                end
            end
            SKIP_SEPARATORS:
            begin
                if (b == jsfe_pkg::CHAR_SPACE || b == jsfe_pkg::CHAR_COLON)
                    ;
                else if (b != jsfe_pkg::CHAR_QUOTE)
                    push_result(8'h00, 1'b0, 1'b1, 1'b0);
                else
                begin
                    phase = IN_VALUE;
                    if (!room_left())
                        push_result(8'h00, 1'b0, 1'b1, 1'b1);
                end
            end
            IN_VALUE:
            begin
                if (!room_left() || b == jsfe_pkg::CHAR_QUOTE)
                    push_result(8'h00, 1'b0, 1'b1, 1'b1);
                else if (b == jsfe_pkg::CHAR_BACKSLASH)
                    phase = IN_ESCAPE;
                else
                    put_value(b);
            end
            IN_ESCAPE:
            begin
                phase = IN_VALUE;
                if (!room_left())
                    push_result(8'h00, 1'b0, 1'b1, 1'b1);
                else
                begin
                    // Map the escape letters; anything else passes as itself
                    if (b == jsfe_pkg::CHAR_N)
                        b = jsfe_pkg::CHAR_LF;
                    else if (b == jsfe_pkg::CHAR_R)
                        b = jsfe_pkg::CHAR_CR;
                    else if (b == jsfe_pkg::CHAR_T)
                        b = jsfe_pkg::CHAR_TAB;
                    put_value(b);
                end
            end
            default: ;
        endcase
    endfunction

    task report_mismatch(string msg);
        errors++;
        $display("MISMATCH at %0t result %0d: %s", $time, result_count, msg);
    endtask

    // Compare one output request with the oldest prediction
    task check_result(jsfe_pkg::out_item_t got);
        jsfe_pkg::out_item_t exp;
        if (awaited.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result %0h", got));
            result_count++;
            return;
        end
        exp = awaited.pop_front();
        if (got.value_byte !== exp.value_byte)
            report_mismatch($sformatf("value_byte %02h, expected %02h",
                                      got.value_byte, exp.value_byte));
        if (got.byte_valid !== exp.byte_valid)
            report_mismatch($sformatf("byte_valid %b, expected %b",
                                      got.byte_valid, exp.byte_valid));
        if (got.finished !== exp.finished)
            report_mismatch($sformatf("finished %b, expected %b",
                                      got.finished, exp.finished));
        if (got.found !== exp.found)
            report_mismatch($sformatf("found %b, expected %b", got.found, exp.found));
        result_count++;
    endtask

    task flush_leftovers();
        while (awaited.size() != 0)
        begin
            void'(awaited.pop_front());
            report_mismatch("expected result never arrived");
        end
    endtask

endclass

module json_string_field_extractor_test;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 6;
    localparam int PHASE_ITEMS  = 52;
    localparam int PHASE_COUNT  = 12;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_stall;
    jsfe_pkg::in_item_t               in_data;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    jsfe_pkg::out_item_t              out_data;
    logic                             cfg_write;
    logic [jsfe_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [jsfe_pkg::CFG_DATA_W-1:0]  cfg_data;

    int unsigned                      send_idle_pct = 0;
    int unsigned                      stall_pct = 0;
    int unsigned                      idle_cycles = 0;
    int unsigned                      text_count = 0;
    logic [7:0]                       key_bytes [jsfe_pkg::KEY_CFG_BYTES];
    jsfe_pkg::in_item_t               doc_q [$];
    field_value_board                 board;

    json_string_field_extractor i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock: 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Stall the output channel at random
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Check results, predict accepted requests, and watch for a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                board.check_result(out_data);
            if (in_valid && !in_stall)
                board.predict_request(in_data);
            if ((out_valid && !out_stall) || (in_valid && !in_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Present one register write; the caller lowers cfg_write afterwards
    task write_register(input jsfe_pkg::cfg_index_t idx, input logic [63:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        board.write_config(idx, data);
        @(negedge clk);
    endtask

    // Load a fresh random key, its length and the buffer limit
    task apply_config(input int unsigned klen, input logic [15:0] lim);
        logic [63:0] word;
        bit          wild;
        int          w;
        int          b;
        wild = ($urandom_range(0, 3) == 0);
        foreach (key_bytes[i])
            key_bytes[i] = wild ? 8'($urandom_range(0, 255)) : 8'($urandom_range(33, 126));
        word = {$urandom, $urandom};
        word[jsfe_pkg::KEY_LEN_W-1:0] = jsfe_pkg::KEY_LEN_W'(klen);
        write_register(jsfe_pkg::CFG_KEY_LENGTH, word);
        for (w = 0; w < jsfe_pkg::KEY_WORDS; w++)
        begin
            for (b = 0; b < 8; b++)
                word[8*b +: 8] = key_bytes[8*w + b];
            write_register(jsfe_pkg::cfg_index_t'(jsfe_pkg::CFG_KEY_WORD_0 + w), word);
        end
        word = {$urandom, $urandom};
        word[jsfe_pkg::LIMIT_W-1:0] = lim;
        write_register(jsfe_pkg::CFG_OUT_LIMIT, word);
        cfg_write <= 1'b0;
    endtask

    // Hold the sender until every predicted result has arrived
    task drain_outputs();
        in_valid <= 1'b0;
        while (board.pending_count() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Offer one request after random idle cycles and wait for acceptance
    task send_request(input jsfe_pkg::in_item_t req);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    function automatic void add_text(logic [7:0] b);
        doc_q.push_back('{text_byte: b, end_of_text: 1'b0});
    endfunction

    // Close the document; the text byte carries noise
    function automatic void add_end();
        doc_q.push_back('{text_byte: 8'($urandom_range(0, 255)), end_of_text: 1'b1});
    endfunction

    task send_document();
        foreach (doc_q[i])
        begin
            send_request(doc_q[i]);
            text_count++;
        end
        doc_q.delete();
    endtask

    // Build one random document, mostly well-formed around the current key
    task build_document(input int unsigned klen);
        int unsigned kind;
        int unsigned kn;
        int unsigned n;
        int unsigned i;
        int unsigned pick;
        logic [7:0]  b;
        kn   = (klen > jsfe_pkg::KEY_CFG_BYTES) ? jsfe_pkg::KEY_CFG_BYTES : klen;
        kind = $urandom_range(0, 9);
        n    = $urandom_range(0, 5);
        for (i = 0; i < n; i++)
            add_text(8'($urandom_range(0, 255)));
        // Noise only, zero bytes frequent: the key is not placed
        if (kind >= 8)
        begin
            n = $urandom_range(1, 15);
            for (i = 0; i < n; i++)
                add_text($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(0, 255)));
            add_end();
            return;
        end
        // Drop a truncated key in quotes before the real one
        if (kn > 1 && $urandom_range(0, 3) == 0)
        begin
            add_text(jsfe_pkg::CHAR_QUOTE);
            for (i = 0; i + 1 < kn; i++)
                add_text(key_bytes[i]);
            add_text(jsfe_pkg::CHAR_QUOTE);
        end
        add_text(jsfe_pkg::CHAR_QUOTE);
        for (i = 0; i < kn; i++)
            add_text(key_bytes[i]);
        add_text(jsfe_pkg::CHAR_QUOTE);
        n = $urandom_range(0, 3);
        for (i = 0; i < n; i++)
            add_text($urandom_range(0, 1) ? jsfe_pkg::CHAR_SPACE : jsfe_pkg::CHAR_COLON);
        // End while still skipping separators
        if (kind == 7)
        begin
            add_end();
            return;
        end
        // Something other than a quote after the key
        if (kind == 6)
        begin
            b = 8'($urandom_range(0, 255));
            add_text((b == jsfe_pkg::CHAR_QUOTE) ? 8'h7B : b);
            n = $urandom_range(0, 4);
            for (i = 0; i < n; i++)
                add_text(8'($urandom_range(0, 255)));
            add_end();
            return;
        end
        add_text(jsfe_pkg::CHAR_QUOTE);
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        for (i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 9);
            if (pick <= 5)
            begin
                b = 8'($urandom_range(32, 126));
                add_text((b == jsfe_pkg::CHAR_QUOTE || b == jsfe_pkg::CHAR_BACKSLASH) ?
                         8'h78 : b);
            end
            else if (pick <= 8)
            begin
                add_text(jsfe_pkg::CHAR_BACKSLASH);
                case ($urandom_range(0, 6))
                    0: add_text(jsfe_pkg::CHAR_N);
                    1: add_text(jsfe_pkg::CHAR_R);
                    2: add_text(jsfe_pkg::CHAR_T);
                    3: add_text(jsfe_pkg::CHAR_QUOTE);
                    4: add_text(jsfe_pkg::CHAR_BACKSLASH);
                    5: add_text(8'h2F);
                    default: add_text(8'($urandom_range(0, 255)));
                endcase
            end
            else
                add_text(8'($urandom_range(0, 255)));
        end
        case ($urandom_range(0, 5))
            0: ;                                    // end inside the value
            1: add_text(jsfe_pkg::CHAR_BACKSLASH);  // end with an escape pending
            default:
            begin
                add_text(jsfe_pkg::CHAR_QUOTE);
                n = $urandom_range(0, 3);
                for (i = 0; i < n; i++)
                    add_text(8'($urandom_range(0, 255)));
            end
        endcase
        add_end();
    endtask

    initial
    begin
        logic [7:0]  directed_text [$];
        int unsigned p;
        int unsigned klen;
        logic [15:0] lim;
        int unsigned phase_start;

        board     = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: key "ab", every escape, extreme bytes, backslash at end
        write_register(jsfe_pkg::CFG_KEY_LENGTH, 64'd2);
        write_register(jsfe_pkg::CFG_KEY_WORD_0, 64'h6261);
        cfg_write <= 1'b0;
        directed_text = '{jsfe_pkg::CHAR_QUOTE, 8'h61, 8'h62, jsfe_pkg::CHAR_QUOTE,
                          jsfe_pkg::CHAR_COLON, jsfe_pkg::CHAR_QUOTE,
                          jsfe_pkg::CHAR_BACKSLASH, jsfe_pkg::CHAR_QUOTE,
                          jsfe_pkg::CHAR_BACKSLASH, jsfe_pkg::CHAR_BACKSLASH,
                          jsfe_pkg::CHAR_BACKSLASH, 8'h2F,
                          jsfe_pkg::CHAR_BACKSLASH, jsfe_pkg::CHAR_N,
                          jsfe_pkg::CHAR_BACKSLASH, jsfe_pkg::CHAR_R,
                          jsfe_pkg::CHAR_BACKSLASH, jsfe_pkg::CHAR_T,
                          jsfe_pkg::CHAR_BACKSLASH, 8'h71, 8'hFF, 8'h00,
                          jsfe_pkg::CHAR_BACKSLASH};
        foreach (directed_text[i])
            add_text(directed_text[i]);
        add_end();
        send_document();

        // Random phases, each with its own settings and idle pattern
        for (p = 0; p < PHASE_COUNT; p++)
        begin
            drain_outputs();
            klen = $urandom_range(1, 8);
            case (p)
                0: begin klen = jsfe_pkg::KEY_CFG_BYTES; lim = 16'd256; end
                1: begin klen = 0; lim = 16'hFFFF; end
                2: begin klen = 63; lim = 16'd256; end
                3: lim = 16'd0;
                4: lim = 16'd1;
                5: lim = 16'd2;
                6: lim = 16'd5;
                7: lim = 16'($urandom_range(0, 65535));
                default: lim = $urandom_range(0, 1) ? 16'($urandom_range(3, 12)) : 16'd256;
            endcase
            apply_config(klen, lim);
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 66; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 66; end
                default: begin send_idle_pct = 11; stall_pct = 11; end
            endcase
            phase_start = text_count;
            while (text_count - phase_start < PHASE_ITEMS)
            begin
                build_document(klen);
                send_document();
            end
        end

        // Wait out the tail, then judge the run
        drain_outputs();
        board.flush_leftovers();
        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
